@@ rtl/core/tcad_pkg.sv @@
// Shared types and codes for the sink-side Type-C attach/detach state machine.
`default_nettype none
package tcad_pkg;

    // port state codes
    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_UNATT = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_ATT   = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;

    // event codes
    localparam logic [2:0] EV_CC_SEEN   = 3'd0;
    localparam logic [2:0] EV_CC_GONE   = 3'd1;
    localparam logic [2:0] EV_VBUS_ON   = 3'd2;
    localparam logic [2:0] EV_CC_DEB    = 3'd3;
    localparam logic [2:0] EV_VBUS_OFF  = 3'd4;
    localparam logic [2:0] EV_ERROR     = 3'd5;
    localparam logic [2:0] EV_PD_DEB    = 3'd6;
    localparam logic [2:0] EV_RECOVERED = 3'd7;

    // timer start codes
    localparam logic [1:0] TMR_NONE = 2'd0;
    localparam logic [1:0] TMR_CC   = 2'd1;
    localparam logic [1:0] TMR_PD   = 2'd2;
    localparam logic [1:0] TMR_ERR  = 2'd3;

    // timer stop mask bits
    localparam logic [2:0] STOP_CC  = 3'b001;
    localparam logic [2:0] STOP_PD  = 3'b010;
    localparam logic [2:0] STOP_ALL = 3'b100;

    // PHY actions
    localparam logic [2:0] PHY_NONE   = 3'd0;
    localparam logic [2:0] PHY_ATTACH = 3'd1;
    localparam logic [2:0] PHY_DETACH = 3'd2;
    localparam logic [2:0] PHY_ERRREC = 3'd3;
    localparam logic [2:0] PHY_RD     = 3'd4;

    // port notices
    localparam logic [1:0] NOTE_NONE   = 2'd0;
    localparam logic [1:0] NOTE_ATT    = 2'd1;
    localparam logic [1:0] NOTE_DETACH = 2'd2;

    localparam int IN_W   = 8;
    localparam int OUT_W  = 24;
    localparam int ITEM_W = 5;
    localparam int RES_W  = 17;

    // one event; last field in the low bits
    typedef struct packed {
        logic       hard_reset_busy;
        logic       sink_tx_ok;
        logic [2:0] cmd;
    } t_item;

    // one result; last field in the low bits
    typedef struct packed {
        logic       clear_session;
        logic       protocol_init;
        logic       fwd_vbus_present;
        logic       fwd_tx_ok;
        logic [1:0] port_notice;
        logic [2:0] phy_action;
        logic [2:0] stop_timers;
        logic [1:0] start_timer;
        logic [2:0] port_state;
    } t_result;

    // connection state carried between events
    typedef struct packed {
        logic [2:0] state;
        logic       cc_debounced;
        logic       vbus_seen;
    } t_conn;

endpackage
`default_nettype wire

@@ rtl/core/tcad_decode.sv @@
// Next-state and result decode for one connection event.
`default_nettype none
module tcad_decode (
    input  tcad_pkg::t_conn   i_conn,
    input  tcad_pkg::t_item   i_item,
    output tcad_pkg::t_conn   o_conn,
    output tcad_pkg::t_result o_res
);
    import tcad_pkg::*;

    t_conn   nxt;
    t_result res;

    always_comb begin
        nxt = i_conn;
        res = '0;
        case (i_item.cmd)
            EV_CC_SEEN: begin
                if (i_conn.state inside {ST_UNATT, ST_NONE}) begin
                    res.stop_timers = STOP_PD;
                    res.start_timer = TMR_CC;
                    nxt.state       = ST_WAIT;
                end else if (i_conn.state == ST_ATT) begin
                    res.fwd_tx_ok = i_item.sink_tx_ok;
                end else if (i_conn.state == ST_WAIT) begin
                    res.stop_timers = STOP_PD;
                    res.start_timer = TMR_CC;
                end
            end
            EV_CC_GONE: begin
                if (i_conn.state == ST_WAIT) begin
                    nxt.cc_debounced = 1'b0;
                    res.stop_timers  = STOP_CC;
                    res.start_timer  = TMR_PD;
                end
            end
            EV_VBUS_ON: begin
                res.fwd_vbus_present = (i_conn.state == ST_ATT);
                if (i_conn.cc_debounced) begin
                    res.protocol_init = 1'b1;
                    res.phy_action    = PHY_ATTACH;
                    res.port_notice   = NOTE_ATT;
                    nxt.state         = ST_ATT;
                    nxt.cc_debounced  = 1'b0;
                end else begin
                    nxt.vbus_seen = 1'b1;
                end
            end
            EV_CC_DEB: begin
                if (i_conn.state == ST_WAIT) begin
                    if (i_conn.vbus_seen) begin
                        res.protocol_init = 1'b1;
                        res.phy_action    = PHY_ATTACH;
                        res.port_notice   = NOTE_ATT;
                        nxt.state         = ST_ATT;
                    end else begin
                        nxt.cc_debounced = 1'b1;
                    end
                end
            end
            EV_VBUS_OFF: begin
                if (!i_item.hard_reset_busy) begin
                    nxt.vbus_seen = 1'b0;
                    if (i_conn.state == ST_ATT) begin
                        res.phy_action    = PHY_DETACH;
                        res.clear_session = 1'b1;
                        res.port_notice   = NOTE_DETACH;
                        res.stop_timers   = STOP_ALL;
                        nxt.state         = ST_UNATT;
                    end
                end
            end
            EV_ERROR: begin
                res.stop_timers = STOP_CC | STOP_PD;
                res.phy_action  = PHY_ERRREC;
                res.start_timer = TMR_ERR;
                nxt.state       = ST_ERR;
            end
            default: begin
                // pd debounce done / recovery done: back to unattached
                if (i_conn.state == ST_ATT) begin
                    res.phy_action    = PHY_DETACH;
                    res.clear_session = 1'b1;
                    res.port_notice   = NOTE_DETACH;
                end else if (i_conn.state == ST_ERR) begin
                    res.phy_action = PHY_RD;
                end
                res.stop_timers = STOP_ALL;
                nxt.state       = ST_UNATT;
            end
        endcase
        res.port_state = nxt.state;
    end

    assign o_conn = nxt;
    assign o_res  = res;

endmodule
`default_nettype wire

@@ rtl/core/typec_attach_detach_fsm.sv @@
// Top level of the sink-side USB Type-C attach/detach state machine.
`default_nettype none
// Each event transfer on the slave stream produces exactly one result transfer
// on the master stream, in order. An accepted event sits in an input register;
// the next-state decode works combinationally from there and updates the port
// state and the two flags as the result is loaded into the output register.
// One event a cycle is sustained while results are read as offered; a result
// is offered on the master stream once its event has moved from the input
// register to the output register, and the block keeps taking events while a
// result waits to be read, up to one held in each register. Reset (synchronous,
// active low) puts the port in state none with both flags clear.
module typec_attach_detach_fsm (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output      logic                         o_s_tready,
    // [2:0] cmd, [3] sink_tx_ok, [4] hard_reset_busy, [7:5] zero
    input  wire logic [tcad_pkg::IN_W-1:0]    i_s_tdata,
    output      logic                         o_m_tvalid,
    input  wire logic                         i_m_tready,
    // [2:0] port_state, [4:3] start_timer, [7:5] stop_timers, [10:8] phy_action,
    // [12:11] port_notice, [13] fwd_tx_ok, [14] fwd_vbus_present,
    // [15] protocol_init, [16] clear_session, [23:17] zero
    output      logic [tcad_pkg::OUT_W-1:0]   o_m_tdata
);
    import tcad_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_conn   r_conn;

    t_conn   n_conn;
    t_result n_out;
    logic    advance;
    logic    in_take;

    // event moves to the output register when that is empty or being read
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    tcad_decode u_decode (
        .i_conn (r_conn),
        .i_item (r_in),
        .o_conn (n_conn),
        .o_res  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_conn      <= '{state: ST_NONE, cc_debounced: 1'b0, vbus_seen: 1'b0};
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_conn      <= n_conn;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_s_tdata[ITEM_W-1:0];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_W-RES_W){1'b0}}, r_out};

`ifndef NO_ASSERTIONS
    // the shown result always carries the state the block now holds
    a_state_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.port_state == r_conn.state)
        else $error("result state differs from held state");

    // a held event is never dropped while the output is stalled
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("pending event lost");

    // an attach action only ever comes with the attached state
    a_attach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.phy_action == PHY_ATTACH |-> r_out.port_state == ST_ATT)
        else $error("attach without attached state");

    // session clear only on a detach into unattached
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.clear_session |->
            r_out.phy_action == PHY_DETACH && r_out.port_state == ST_UNATT)
        else $error("session clear without detach");

    // error-recovery timer is started only on entry to error recovery
    a_err_tmr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.start_timer == TMR_ERR |-> r_out.port_state == ST_ERR)
        else $error("recovery timer outside error recovery");
`endif

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the sink-side Type-C attach/detach state machine.
`timescale 1ns / 1ps

module testbench;
    import tcad_pkg::*;

    // Clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Slave side (events into the block), driven at the falling edge
    logic              s_valid = 1'b0;
    logic [IN_W-1:0]   s_data  = '0;
    logic              s_ready;

    // Master side (results out of the block), sampled at the rising edge
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [OUT_W-1:0]  m_data;

    // Event stimulus waiting for its transfer, and results still owed by the block
    t_item   pending_events[$];
    t_result expected_results[$];

    // Connection state as this bench believes it to be, starting as after reset
    t_conn   link = '{state: ST_NONE, cc_debounced: 1'b0, vbus_seen: 1'b0};

    int  n_taken    = 0;   // event transfers so far
    int  n_errors   = 0;
    bit  live       = 1'b0; // reset seen released at a rising edge
    bit  s_took     = 1'b0; // event transfer at the last rising edge
    bit  stall_done = 1'b0;
    int  stall_left = 0;
    bit  calm;              // idle-free stretch on both sides

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    typec_attach_detach_fsm DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        // [2:0] cmd, [3] sink_tx_ok, [4] hard_reset_busy, [7:5] zero
        .i_s_tdata  (s_data),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        // [2:0] port_state, [4:3] start_timer, [7:5] stop_timers, [10:8] phy_action,
        // [12:11] port_notice, [13] fwd_tx_ok, [14] fwd_vbus_present,
        // [15] protocol_init, [16] clear_session, [23:17] zero
        .o_m_tdata  (m_data)
    );

    assign calm = (n_taken >= 300) && (n_taken < 700);

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Attach: protocol stack reinitialised, PHY told to attach, port notified.
    function automatic void enter_attached(inout t_result r);
        r.protocol_init = 1'b1;
        r.phy_action    = PHY_ATTACH;
        r.port_notice   = NOTE_ATT;
        link.state      = ST_ATT;
    endfunction

    // Detach/unattach: side effects depend on where we come from.
    function automatic void enter_unattached(inout t_result r);
        if (link.state == ST_ATT) begin
            r.phy_action    = PHY_DETACH;
            r.clear_session = 1'b1;
            r.port_notice   = NOTE_DETACH;
        end else if (link.state == ST_ERR) begin
            r.phy_action = PHY_RD;
        end
        r.stop_timers = r.stop_timers | STOP_ALL;
        link.state    = ST_UNATT;
    endfunction

    function automatic t_result apply_event(input t_item ev);
        t_result r;
        r = '0;
        case (ev.cmd)
            EV_CC_SEEN: begin
                // none/unattached move to attach-wait; in attach-wait the
                // debounce simply restarts; attached only forwards tx-ok
                if (link.state == ST_NONE || link.state == ST_UNATT ||
                    link.state == ST_WAIT) begin
                    r.stop_timers = r.stop_timers | STOP_PD;
                    r.start_timer = TMR_CC;
                    link.state    = ST_WAIT;
                end else if (link.state == ST_ATT) begin
                    r.fwd_tx_ok = ev.sink_tx_ok;
                end
            end
            EV_CC_GONE: begin
                if (link.state == ST_WAIT) begin
                    link.cc_debounced = 1'b0;
                    r.stop_timers     = r.stop_timers | STOP_CC;
                    r.start_timer     = TMR_PD;
                end
            end
            EV_VBUS_ON: begin
                if (link.state == ST_ATT)
                    r.fwd_vbus_present = 1'b1;
                // with CC already debounced, VBUS attaches from any state,
                // attached included
                if (link.cc_debounced) begin
                    enter_attached(r);
                    link.cc_debounced = 1'b0;
                end else begin
                    link.vbus_seen = 1'b1;
                end
            end
            EV_CC_DEB: begin
                if (link.state == ST_WAIT) begin
                    if (link.vbus_seen)
                        enter_attached(r);
                    else
                        link.cc_debounced = 1'b1;
                end
            end
            EV_VBUS_OFF: begin
                // ignored entirely while a hard reset is running
                if (!ev.hard_reset_busy) begin
                    link.vbus_seen = 1'b0;
                    if (link.state == ST_ATT)
                        enter_unattached(r);
                end
            end
            EV_ERROR: begin
                r.stop_timers = r.stop_timers | STOP_CC | STOP_PD;
                r.phy_action  = PHY_ERRREC;
                r.start_timer = TMR_ERR;
                link.state    = ST_ERR;
            end
            default: begin
                // pd debounce done and recovery done both unattach
                enter_unattached(r);
            end
        endcase
        r.port_state = link.state;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    task automatic add_event(input logic [2:0] cmd, input bit txok, input bit hrst);
        t_item it;
        it.cmd             = cmd;
        it.sink_tx_ok      = txok;
        it.hard_reset_busy = hrst;
        pending_events.push_back(it);
    endtask

    function automatic bit coin();
        return bit'($urandom_range(1));
    endfunction

    // hard reset busy on roughly a quarter of the VBUS-off events it is used for
    function automatic bit hrst_bit();
        return $urandom_range(3) == 0;
    endfunction

    // A full attach attempt with random content: attach-wait, debounce and
    // VBUS in either order, traffic while attached, then one way out.
    task automatic add_attach_run();
        int n;
        add_event(EV_CC_SEEN, coin(), coin());
        n = $urandom_range(2);
        repeat (n) add_event(EV_CC_SEEN, coin(), coin());
        if (coin()) begin
            add_event(EV_CC_DEB, coin(), coin());
            add_event(EV_CC_GONE, coin(), coin());
            add_event(EV_CC_SEEN, coin(), coin());
        end
        if (coin()) begin
            add_event(EV_CC_DEB, coin(), coin());
            add_event(EV_VBUS_ON, coin(), coin());
        end else begin
            add_event(EV_VBUS_ON, coin(), coin());
            add_event(EV_CC_DEB, coin(), coin());
        end
        n = $urandom_range(4);
        repeat (n) add_event(coin() ? EV_CC_SEEN : EV_VBUS_ON, coin(), coin());
        case ($urandom_range(3))
            0: begin
                add_event(EV_VBUS_OFF, coin(), 1'b1);
                add_event(EV_VBUS_OFF, coin(), 1'b0);
            end
            1: add_event(EV_VBUS_OFF, coin(), hrst_bit());
            2: begin
                add_event(EV_ERROR, coin(), coin());
                add_event(EV_RECOVERED, coin(), coin());
            end
            default: add_event(EV_PD_DEB, coin(), coin());
        endcase
    endtask

    initial begin : stimulus
        int pick;
        int n;

        // Directed opening: every event, every state, each side effect
        add_event(EV_CC_GONE,   1'b0, 1'b0);   // ignored in state none
        add_event(EV_VBUS_OFF,  1'b1, 1'b1);   // ignored, hard reset busy
        add_event(EV_CC_SEEN,   1'b1, 1'b0);   // none -> attach-wait
        add_event(EV_CC_SEEN,   1'b0, 1'b1);   // debounce restart in attach-wait
        add_event(EV_CC_GONE,   1'b1, 1'b1);   // start pd debounce
        add_event(EV_CC_DEB,    1'b0, 1'b0);   // cc debounced, no vbus yet
        add_event(EV_VBUS_ON,   1'b0, 1'b0);   // attach via vbus
        add_event(EV_CC_SEEN,   1'b1, 1'b0);   // tx-ok forwarded
        add_event(EV_CC_SEEN,   1'b0, 1'b0);   // tx-ok not forwarded
        add_event(EV_VBUS_ON,   1'b1, 1'b1);   // vbus forwarded while attached
        add_event(EV_CC_DEB,    1'b1, 1'b0);   // ignored while attached
        add_event(EV_VBUS_OFF,  1'b0, 1'b1);   // ignored, hard reset busy
        add_event(EV_VBUS_OFF,  1'b1, 1'b0);   // detach from attached
        add_event(EV_CC_GONE,   1'b0, 1'b0);   // ignored while unattached
        add_event(EV_ERROR,     1'b1, 1'b1);   // error recovery
        add_event(EV_CC_SEEN,   1'b1, 1'b1);   // ignored in error recovery
        add_event(EV_RECOVERED, 1'b0, 1'b0);   // back to unattached, assert Rd
        add_event(EV_PD_DEB,    1'b1, 1'b0);   // unattached again, plain
        add_event(EV_VBUS_ON,   1'b0, 1'b1);   // vbus noted while unattached
        add_event(EV_CC_SEEN,   1'b0, 1'b0);
        add_event(EV_CC_DEB,    1'b1, 1'b1);   // attach via debounce with vbus seen
        add_event(EV_ERROR,     1'b0, 1'b0);   // error from attached
        add_event(EV_PD_DEB,    1'b0, 1'b1);   // error recovery -> unattached

        // Random part: well-formed runs and noise in equal shares, some short flows
        while (pending_events.size() < 1650) begin
            pick = $urandom_range(9);
            case (pick)
                0, 1, 2, 3: add_attach_run();
                4: begin
                    add_event(EV_CC_SEEN, coin(), coin());
                    if (coin()) add_event(EV_CC_DEB, coin(), coin());
                    add_event(EV_CC_GONE, coin(), coin());
                    add_event(EV_PD_DEB, coin(), coin());
                end
                5: begin
                    add_event(EV_ERROR, coin(), coin());
                    if (coin()) add_event(EV_VBUS_ON, coin(), coin());
                    add_event(coin() ? EV_RECOVERED : EV_PD_DEB, coin(), coin());
                end
                default: begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                        add_event(3'($urandom_range(7)), coin(), coin());
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Event transfers: prediction at the rising edge, driving at the falling
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : event_accept
        t_item it;
        live = i_rst_n;
        if (i_rst_n && s_valid && s_ready) begin
            it = pending_events.pop_front();
            expected_results.push_back(apply_event(it));
            n_taken++;
            s_took = 1'b1;
        end
    end

    always @(negedge i_clk) begin : event_driver
        if (!live) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            // current item gone (or none offered): offer the next, or idle
            s_took = 1'b0;
            if (pending_events.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
                s_valid <= 1'b1;
                s_data  <= {{(IN_W-ITEM_W){1'b0}}, pending_events[0]};
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result transfers: back-pressure at the falling edge, checking at the rising
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin : result_ready
        if (!live) begin
            m_ready <= 1'b0;
        end else begin
            // one long hold-off so both registers fill and the input stalls
            if (!stall_done && n_taken >= 1000) begin
                stall_done = 1'b1;
                stall_left = 80;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 13);
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_valid && m_ready) begin
            got = t_result'(m_data[RES_W-1:0]);
            if (expected_results.size() == 0) begin
                $error("result transfer with no expectation outstanding: %h", m_data);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("port_state",       want.port_state,       got.port_state);
                check_field("start_timer",      want.start_timer,      got.start_timer);
                check_field("stop_timers",      want.stop_timers,      got.stop_timers);
                check_field("phy_action",       want.phy_action,       got.phy_action);
                check_field("port_notice",      want.port_notice,      got.port_notice);
                check_field("fwd_tx_ok",        want.fwd_tx_ok,        got.fwd_tx_ok);
                check_field("fwd_vbus_present", want.fwd_vbus_present, got.fwd_vbus_present);
                check_field("protocol_init",    want.protocol_init,    got.protocol_init);
                check_field("clear_session",    want.clear_session,    got.clear_session);
                check_field("tdata padding",    0,                     m_data[OUT_W-1:RES_W]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------

    initial begin : run_control
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // all events transferred, then all results in, then a short drain
        @(posedge i_clk);
        while (pending_events.size() != 0 || s_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin : watchdog
        #200000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
